>>> hdl/mmnp_pkg.sv
// ----------------------------------------------------------------------------
// mmnp_pkg
// Shared constants and types for the monophonic last-note-priority voice
// assigner: stack sizing, MIDI message codes, reset values, sequencer states.
// ----------------------------------------------------------------------------
package mmnp_pkg;

    // held-note stack
    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // message types (upper nibble of the status byte)
    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_CTRL     = 4'hB;
    localparam logic [3:0] MSG_PRESSURE = 4'hD;
    localparam logic [3:0] MSG_BEND     = 4'hE;

    // controller numbers
    localparam logic [6:0] CC_MOD_WHEEL  = 7'd1;
    localparam logic [6:0] CC_BRIGHTNESS = 7'd74;
    localparam logic [6:0] CC_SOUND_OFF  = 7'd120;
    localparam logic [6:0] CC_NOTES_OFF  = 7'd123;

    // message lengths
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // reset values
    localparam logic [6:0]  RST_NOTE     = 7'd60;
    localparam logic [6:0]  RST_VELOCITY = 7'd127;
    localparam logic [13:0] RST_BEND     = 14'd8192;

    // word widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 64;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_SHIFT  = 5'b00100,
        ST_FETCH  = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

endpackage

>>> hdl/midi_mono_note_priority_unit.sv
// ----------------------------------------------------------------------------
// midi_mono_note_priority_unit
// Monophonic last-note-priority voice assigner driven by MIDI messages.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one MIDI message a word (status, two data bytes
//   and the byte count); the channel nibble is ignored. The master channel
//   gives exactly one result word for every message: the note now playing,
//   last velocity, start/stop/legato flags, controller levels, pitch bend and
//   the number of held notes.
//   Note messages walk the held-note stack one entry a cycle through a single
//   compare and move path: a search up to the held count, then a shift of the
//   entries above the found one, then, when a note is released, a read of the
//   newest entry. Controllers, bend, pressure and ignored messages go straight
//   to the output step; s_tready is low from acceptance until the result word
//   is registered.
//   The result sits in an output register. When the receiver stalls the block
//   finishes its work and then waits for the register to drain before taking
//   the next message.
//   After reset: no notes held, note 60 playing, velocity 127, wheel and
//   pressure 0, bend centred at 8192. Stack contents need no clearing.
// ----------------------------------------------------------------------------
module midi_mono_note_priority_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // status_byte[7:0], data_one[14:8], data_two[21:15], msg_length[23:22]
    input  logic [mmnp_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // play_note[6:0], note_velocity[13:7], note_start[14], note_stop[15],
    // legato_retarget[16], mod_wheel[23:17], channel_pressure[30:24],
    // bend_value[44:31], brightness_valid[45], brightness[52:46],
    // held_count[57:53], zero fill [63:58]
    output logic [mmnp_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int IDX_W = mmnp_pkg::IDX_W;
    localparam int CNT_W = mmnp_pkg::CNT_W;

    // input fields
    logic [7:0] in_status;
    logic [6:0] in_d1;
    logic [6:0] in_d2;
    logic [1:0] in_len;
    logic [3:0] in_type;

    assign in_status = s_tdata[7:0];
    assign in_d1     = s_tdata[14:8];
    assign in_d2     = s_tdata[21:15];
    assign in_len    = s_tdata[23:22];
    assign in_type   = in_status[7:4];

    mmnp_pkg::state_t state_reg, state_next;

    logic [6:0]       held_reg [mmnp_pkg::STACK_DEPTH];
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [6:0]       key_reg, key_next;
    logic             push_reg, push_next;

    logic [6:0]  note_reg, note_next;
    logic [6:0]  vel_reg, vel_next;
    logic [6:0]  wheel_reg, wheel_next;
    logic [6:0]  press_reg, press_next;
    logic [13:0] bend_reg, bend_next;
    logic        start_reg, start_next;
    logic        stop_reg, stop_next;
    logic        retgt_reg, retgt_next;
    logic        bvalid_reg, bvalid_next;
    logic [6:0]  bright_reg, bright_next;

    logic                      m_valid_reg, m_valid_next;
    logic [mmnp_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    // shared stack access path
    logic [CNT_W-1:0] idx_m1;
    logic [CNT_W-1:0] top_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [6:0]       rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [6:0]       wr_data;
    logic             accept;
    logic             out_free;

    assign idx_m1   = idx_reg - CNT_W'(1);
    assign top_idx  = total_reg - CNT_W'(1);
    assign rd_idx   = (state_reg == mmnp_pkg::ST_FETCH) ? top_idx[IDX_W-1:0]
                                                        : idx_reg[IDX_W-1:0];
    assign rd_data  = held_reg[rd_idx];

    assign s_tready = (state_reg == mmnp_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next  = state_reg;
        total_next  = total_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        push_next   = push_reg;
        note_next   = note_reg;
        vel_next    = vel_reg;
        wheel_next  = wheel_reg;
        press_next  = press_reg;
        bend_next   = bend_reg;
        start_next  = start_reg;
        stop_next   = stop_reg;
        retgt_next  = retgt_reg;
        bvalid_next = bvalid_reg;
        bright_next = bright_reg;
        wr_en       = 1'b0;
        wr_idx      = idx_m1[IDX_W-1:0];
        wr_data     = rd_data;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        case (state_reg)
            mmnp_pkg::ST_IDLE: begin
                if (accept) begin
                    start_next  = 1'b0;
                    stop_next   = 1'b0;
                    retgt_next  = 1'b0;
                    bvalid_next = 1'b0;
                    bright_next = 7'd0;
                    key_next    = in_d1;
                    idx_next    = '0;
                    push_next   = 1'b0;
                    state_next  = mmnp_pkg::ST_OUT;
                    case (in_type)
                        mmnp_pkg::MSG_NOTE_OFF: begin
                            if (in_len >= mmnp_pkg::LEN_TWO) begin
                                state_next = mmnp_pkg::ST_SEARCH;
                            end
                        end
                        mmnp_pkg::MSG_NOTE_ON: begin
                            if (in_len == mmnp_pkg::LEN_THREE) begin
                                state_next = mmnp_pkg::ST_SEARCH;
                                if (in_d2 != 7'd0) begin
                                    push_next  = 1'b1;
                                    note_next  = in_d1;
                                    vel_next   = in_d2;
                                    start_next = 1'b1;
                                end
                            end
                        end
                        mmnp_pkg::MSG_CTRL: begin
                            if (in_len == mmnp_pkg::LEN_THREE) begin
                                if (in_d1 == mmnp_pkg::CC_MOD_WHEEL) begin
                                    wheel_next = in_d2;
                                end
                                if (in_d1 == mmnp_pkg::CC_BRIGHTNESS) begin
                                    bvalid_next = 1'b1;
                                    bright_next = in_d2;
                                end
                                if (in_d1 == mmnp_pkg::CC_SOUND_OFF ||
                                    in_d1 == mmnp_pkg::CC_NOTES_OFF) begin
                                    total_next = '0;
                                    stop_next  = 1'b1;
                                end
                            end
                        end
                        mmnp_pkg::MSG_PRESSURE: begin
                            if (in_len >= mmnp_pkg::LEN_TWO) begin
                                press_next = in_d1;
                            end
                        end
                        mmnp_pkg::MSG_BEND: begin
                            if (in_len == mmnp_pkg::LEN_THREE) begin
                                bend_next = {in_d2, in_d1};
                            end
                        end
                        default: begin
                        end
                    endcase
                    // a zero-length message is dropped whatever its type
                    if (in_len == 2'd0) begin
                        state_next  = mmnp_pkg::ST_OUT;
                        push_next   = 1'b0;
                        note_next   = note_reg;
                        vel_next    = vel_reg;
                        start_next  = 1'b0;
                        stop_next   = 1'b0;
                        bvalid_next = 1'b0;
                        bright_next = 7'd0;
                        total_next  = total_reg;
                        wheel_next  = wheel_reg;
                        press_next  = press_reg;
                        bend_next   = bend_reg;
                    end
                end
            end

            mmnp_pkg::ST_SEARCH: begin
                if (idx_reg == total_reg) begin
                    // not held
                    if (!push_reg) begin
                        state_next = mmnp_pkg::ST_FETCH;
                    end else if (total_reg < CNT_W'(mmnp_pkg::STACK_DEPTH)) begin
                        wr_en      = 1'b1;
                        wr_idx     = total_reg[IDX_W-1:0];
                        wr_data    = key_reg;
                        total_next = total_reg + CNT_W'(1);
                        state_next = mmnp_pkg::ST_OUT;
                    end else begin
                        // full: drop the oldest entry
                        idx_next   = CNT_W'(1);
                        state_next = mmnp_pkg::ST_SHIFT;
                    end
                end else if (rd_data == key_reg) begin
                    if (push_reg) begin
                        state_next = mmnp_pkg::ST_OUT;
                    end else begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = mmnp_pkg::ST_SHIFT;
                    end
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            mmnp_pkg::ST_SHIFT: begin
                if (idx_reg == total_reg) begin
                    if (push_reg) begin
                        wr_en      = 1'b1;
                        wr_idx     = top_idx[IDX_W-1:0];
                        wr_data    = key_reg;
                        state_next = mmnp_pkg::ST_OUT;
                    end else begin
                        total_next = top_idx;
                        state_next = mmnp_pkg::ST_FETCH;
                    end
                end else begin
                    // move one entry down
                    wr_en    = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            mmnp_pkg::ST_FETCH: begin
                if (total_reg == '0) begin
                    stop_next = 1'b1;
                end else begin
                    note_next  = rd_data;
                    retgt_next = 1'b1;
                end
                state_next = mmnp_pkg::ST_OUT;
            end

            mmnp_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, total_reg, bright_reg, bvalid_reg,
                                    bend_reg, press_reg, wheel_reg, retgt_reg,
                                    stop_reg, start_reg, vel_reg, note_reg};
                    state_next   = mmnp_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = mmnp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mmnp_pkg::ST_IDLE;
            total_reg   <= '0;
            note_reg    <= mmnp_pkg::RST_NOTE;
            vel_reg     <= mmnp_pkg::RST_VELOCITY;
            wheel_reg   <= 7'd0;
            press_reg   <= 7'd0;
            bend_reg    <= mmnp_pkg::RST_BEND;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            note_reg    <= note_next;
            vel_reg     <= vel_next;
            wheel_reg   <= wheel_next;
            press_reg   <= press_next;
            bend_reg    <= bend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        push_reg   <= push_next;
        start_reg  <= start_next;
        stop_reg   <= stop_next;
        retgt_reg  <= retgt_next;
        bvalid_reg <= bvalid_next;
        bright_reg <= bright_next;
        m_data_reg <= m_data_next;
        if (wr_en) begin
            held_reg[wr_idx] <= wr_data;
        end
    end

endmodule
